// ===== src/naes64_pkg.sv =====
// Package for the nibble AES-64 cipher: tables, register indexes, command struct
// and the GF(2^4) round functions. Used by the controller, the datapath and the top level.
// Depends on nothing.
package naes64_pkg;

  localparam int BLOCK_W   = 64;
  localparam int ROUND_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_CIPHER_KEY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROUND_COUNT = 2'd1;

  localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 4'd4;

  localparam logic [3:0] FWD_BOX [16] = '{
    4'h8, 4'hC, 4'hB, 4'h3, 4'h7, 4'h9, 4'h1, 4'h4,
    4'hE, 4'h6, 4'h0, 4'hD, 4'h2, 4'hF, 4'h5, 4'hA
  };
  localparam logic [3:0] INV_BOX [16] = '{
    4'hA, 4'h6, 4'hC, 4'h3, 4'h7, 4'hE, 4'h9, 4'h4,
    4'h0, 4'h5, 4'hF, 4'h2, 4'h1, 4'hB, 4'h8, 4'hD
  };
  localparam logic [3:0] ROW_PERM [16] = '{
    4'h0, 4'hD, 4'hA, 4'h7, 4'h4, 4'h1, 4'hE, 4'hB,
    4'h8, 4'h5, 4'h2, 4'hF, 4'hC, 4'h9, 4'h6, 4'h3
  };
  localparam logic [3:0] MIX_FWD [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
  localparam logic [3:0] MIX_INV [4] = '{4'd14, 4'd11, 4'd13, 4'd9};
  localparam logic [4:0] GF_POLY = 5'h13;

  typedef struct packed {
    logic               load;
    logic               enc;
    logic               round;
    logic               first;
    logic               last;
    logic               out_load;
    logic               hold_load;
    logic               expand;
    logic [ROUND_W-1:0] key_idx;
    logic [ROUND_W-1:0] exp_idx;
  } cmd_t;

  function automatic logic [15:0] round_const(input logic [ROUND_W-1:0] idx);
    logic [15:0] rc;
    unique case (idx)
      4'd0:    rc = 16'h0100;
      4'd1:    rc = 16'h0200;
      4'd2:    rc = 16'h0400;
      4'd3:    rc = 16'h0800;
      4'd4:    rc = 16'h0300;
      4'd5:    rc = 16'h0600;
      4'd6:    rc = 16'h0C00;
      4'd7:    rc = 16'h0B00;
      4'd8:    rc = 16'h0500;
      4'd9:    rc = 16'h0A00;
      default: rc = 16'h0000;
    endcase
    return rc;
  endfunction

  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] m);
    logic [4:0] x;
    logic [3:0] r;
    r = 4'h0;
    x = {1'b0, a};
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        r = r ^ x[3:0];
      end
      x = {x[3:0], 1'b0};
      if (x[4]) begin
        x = x ^ GF_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] b,
                                                     input logic inv);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int p = 0; p < 16; p++) begin
      r[63-4*p -: 4] = inv ? INV_BOX[b[63-4*p -: 4]] : FWD_BOX[b[63-4*p -: 4]];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] shift_rows_fwd(input logic [BLOCK_W-1:0] b);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int p = 0; p < 16; p++) begin
      r[63-4*int'(ROW_PERM[p]) -: 4] = b[63-4*p -: 4];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] shift_rows_inv(input logic [BLOCK_W-1:0] b);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int p = 0; p < 16; p++) begin
      r[63-4*p -: 4] = b[63-4*int'(ROW_PERM[p]) -: 4];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] b,
                                                     input logic fwd);
    logic [BLOCK_W-1:0] r;
    logic [3:0]         acc;
    logic [3:0]         coef;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        acc = 4'h0;
        for (int k = 0; k < 4; k++) begin
          coef = fwd ? MIX_FWD[2'(k - row)] : MIX_INV[2'(k - row)];
          acc  = acc ^ gf_mul(b[63-4*(4*c+k) -: 4], coef);
        end
        r[63-4*(4*c+row) -: 4] = acc;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/naes64_ctrl.sv =====
// Controller for the nibble AES-64 cipher: handshakes, round sequencing and
// key expansion sequencing. Drives the datapath through naes64_pkg::cmd_t.
// Depends on naes64_pkg.
module naes64_ctrl #(
  parameter int MAX_ROUNDS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            key_write,
  input  logic                            count_write,
  input  logic [naes64_pkg::ROUND_W-1:0]  count_data,
  output naes64_pkg::cmd_t                cmd
);

  localparam logic [1:0] ST_EXPAND = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  localparam logic [naes64_pkg::ROUND_W-1:0] MAX_NR = naes64_pkg::ROUND_W'(MAX_ROUNDS);
  localparam logic [naes64_pkg::ROUND_W-1:0] ONE    = naes64_pkg::ROUND_W'(1);

  logic [1:0]                      state, state_next;
  logic [naes64_pkg::ROUND_W-1:0]  rnd, rnd_next;
  logic [naes64_pkg::ROUND_W-1:0]  exp_cnt, exp_cnt_next;
  logic [naes64_pkg::ROUND_W-1:0]  round_count;
  logic                            enc, enc_next;
  logic                            out_valid_next;
  logic [naes64_pkg::ROUND_W-1:0]  nr;
  logic                            last;
  logic                            out_free;

  always_comb begin
    priority if (round_count == '0) begin
      nr = ONE;
    end else if (round_count > MAX_NR) begin
      nr = MAX_NR;
    end else begin
      nr = round_count;
    end
  end

  assign last     = (rnd == nr - ONE);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    rnd_next     = rnd;
    exp_cnt_next = exp_cnt;
    enc_next     = enc;
    cmd          = '0;
    cmd.enc      = (state == ST_IDLE) ? op : enc;
    cmd.first    = (rnd == '0);
    cmd.last     = last;
    cmd.key_idx  = enc ? rnd : (nr - ONE - rnd);
    cmd.exp_idx  = exp_cnt;
    unique case (state)
      ST_EXPAND: begin
        cmd.expand = 1'b1;
        if (exp_cnt == MAX_NR - ONE) begin
          state_next = ST_IDLE;
        end else begin
          exp_cnt_next = exp_cnt + ONE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          enc_next   = op;
          rnd_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        if (last) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          rnd_next = rnd + ONE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.hold_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (key_write) begin
      state_next   = ST_EXPAND;
      exp_cnt_next = '0;
    end
  end

  always_comb begin
    if (cmd.out_load || cmd.hold_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_EXPAND;
      exp_cnt     <= '0;
      rnd         <= '0;
      enc         <= 1'b0;
      out_valid   <= 1'b0;
      round_count <= naes64_pkg::ROUND_COUNT_RESET;
    end else begin
      state     <= state_next;
      exp_cnt   <= exp_cnt_next;
      rnd       <= rnd_next;
      enc       <= enc_next;
      out_valid <= out_valid_next;
      if (count_write) begin
        round_count <= count_data;
      end
    end
  end

endmodule

// ===== src/naes64_datapath.sv =====
// Datapath for the nibble AES-64 cipher: key register, round key store, key
// expansion step, shared round unit, state and output registers.
// Depends on naes64_pkg; driven by naes64_ctrl.
module naes64_datapath #(
  parameter int MAX_ROUNDS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             key_write,
  input  logic [naes64_pkg::BLOCK_W-1:0]   key_data,
  input  logic [naes64_pkg::BLOCK_W-1:0]   data_block,
  input  naes64_pkg::cmd_t                 cmd,
  output logic [naes64_pkg::BLOCK_W-1:0]   result_block
);

  localparam int IDX_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  logic [naes64_pkg::BLOCK_W-1:0] cipher_key;
  logic [naes64_pkg::BLOCK_W-1:0] exp_cur;
  logic [naes64_pkg::BLOCK_W-1:0] rk_store [MAX_ROUNDS];
  logic [naes64_pkg::BLOCK_W-1:0] blk;

  logic [naes64_pkg::BLOCK_W-1:0] exp_src;
  logic [naes64_pkg::BLOCK_W-1:0] exp_next;
  logic [15:0]                    rot_word;
  logic [15:0]                    sub_word;
  logic [15:0]                    w1, w2, w3, w4;
  logic [naes64_pkg::BLOCK_W-1:0] round_key;
  logic [naes64_pkg::BLOCK_W-1:0] enc_out;
  logic [naes64_pkg::BLOCK_W-1:0] dec_out;
  logic [naes64_pkg::BLOCK_W-1:0] round_out;

  assign exp_src  = (cmd.exp_idx == '0) ? cipher_key : exp_cur;
  assign rot_word = {exp_src[11:0], exp_src[15:12]};

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      sub_word[4*n +: 4] = naes64_pkg::FWD_BOX[rot_word[4*n +: 4]];
    end
  end

  assign w1       = sub_word ^ exp_src[63:48] ^ naes64_pkg::round_const(cmd.exp_idx);
  assign w2       = w1 ^ exp_src[47:32];
  assign w3       = w2 ^ exp_src[31:16];
  assign w4       = w3 ^ exp_src[15:0];
  assign exp_next = {w1, w2, w3, w4};

  assign round_key = rk_store[cmd.key_idx[IDX_W-1:0]];

  always_comb begin
    enc_out = naes64_pkg::shift_rows_fwd(naes64_pkg::sub_nibbles(blk, 1'b0));
    if (!cmd.last) begin
      enc_out = naes64_pkg::mix_columns(enc_out, 1'b1);
    end
    enc_out = enc_out ^ round_key;

    dec_out = blk ^ round_key;
    if (!cmd.first) begin
      dec_out = naes64_pkg::mix_columns(dec_out, 1'b0);
    end
    dec_out = naes64_pkg::sub_nibbles(naes64_pkg::shift_rows_inv(dec_out), 1'b1);
    if (cmd.last) begin
      dec_out = dec_out ^ cipher_key;
    end

    round_out = cmd.enc ? enc_out : dec_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (key_write) begin
      cipher_key <= key_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.expand) begin
      exp_cur                          <= exp_next;
      rk_store[cmd.exp_idx[IDX_W-1:0]] <= exp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk <= cmd.enc ? (data_block ^ cipher_key) : data_block;
    end else if (cmd.round) begin
      blk <= round_out;
    end
    if (cmd.out_load) begin
      result_block <= round_out;
    end else if (cmd.hold_load) begin
      result_block <= blk;
    end
  end

endmodule

// ===== src/nibble_aes64_cipher.sv =====
// Top level of the nibble AES-64 cipher: configuration decode, controller and datapath.
// Depends on naes64_pkg, naes64_ctrl and naes64_datapath.
//
// Use: an input beat carries op (1 encrypt, 0 decrypt) and a 64-bit data_block
// on in_valid/in_ready; one output beat carries result_block on out_valid/out_ready.
// cfg_write with cfg_index selects cipher_key (0) or round_count (1); other
// indexes are ignored. A round_count of 0 runs one round, values above
// MAX_ROUNDS run MAX_ROUNDS.
// Encryption whitens the block with cipher_key as it is loaded, decryption after
// its last round; the rounds run one after another on the shared round unit.
// Unless the receiver stalls, the last round writes the result into the output register.
// After reset, and after every cipher_key write, the key schedule fills the round
// key store one key per cycle up to MAX_ROUNDS keys; in_ready stays low meanwhile.
// One block is processed at a time. A finished result sits in the output register,
// and the next block is accepted while it waits. If the receiver still stalls when
// the following block completes, that block is held and in_ready stays low until
// the output register frees up.
module nibble_aes64_cipher #(
  parameter int MAX_ROUNDS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [naes64_pkg::BLOCK_W-1:0]     data_block,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [naes64_pkg::BLOCK_W-1:0]     result_block,
  input  logic                               cfg_write,
  input  logic [naes64_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [naes64_pkg::BLOCK_W-1:0]     cfg_data
);

  naes64_pkg::cmd_t cmd;
  logic             key_write;
  logic             count_write;

  assign key_write   = cfg_write && (cfg_index == naes64_pkg::REG_CIPHER_KEY);
  assign count_write = cfg_write && (cfg_index == naes64_pkg::REG_ROUND_COUNT);

  naes64_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_write   (key_write),
    .count_write (count_write),
    .count_data  (cfg_data[naes64_pkg::ROUND_W-1:0]),
    .cmd         (cmd)
  );

  naes64_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key_write    (key_write),
    .key_data     (cfg_data),
    .data_block   (data_block),
    .cmd          (cmd),
    .result_block (result_block)
  );

`ifndef NO_ASSERTIONS
  a_key_write_blocks_input: assert property (@(posedge clk) disable iff (rst)
    key_write |=> !in_ready)
    else $error("input accepted during key expansion");

  a_one_block_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second block accepted while one is in flight");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result presented without a block in flight");
`endif

endmodule

// ===== sim/nibble_aes64_cipher_test.sv =====
// Self-checking testbench for nibble_aes64_cipher: a table of directed beats and register
// writes, then random phases of blocks checked against a predictor of the cipher built here.
// Depends on naes64_pkg and the nibble_aes64_cipher RTL.
module nibble_aes64_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int ROUNDS_MAX  = 10;
  localparam int ITEMS       = 600;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 400000;

  localparam int IDX_W = naes64_pkg::REG_IDX_W;

  localparam logic OP_ENCRYPT = 1'b1;
  localparam logic OP_DECRYPT = 1'b0;

  localparam logic [IDX_W-1:0] REG_KEY     = naes64_pkg::REG_CIPHER_KEY;
  localparam logic [IDX_W-1:0] REG_COUNT   = naes64_pkg::REG_ROUND_COUNT;
  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [3:0] SBOX [16] = '{
    4'h8, 4'hC, 4'hB, 4'h3, 4'h7, 4'h9, 4'h1, 4'h4,
    4'hE, 4'h6, 4'h0, 4'hD, 4'h2, 4'hF, 4'h5, 4'hA
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'hA, 4'h6, 4'hC, 4'h3, 4'h7, 4'hE, 4'h9, 4'h4,
    4'h0, 4'h5, 4'hF, 4'h2, 4'h1, 4'hB, 4'h8, 4'hD
  };
  localparam logic [15:0] RCON [10] = '{
    16'h0100, 16'h0200, 16'h0400, 16'h0800, 16'h0300,
    16'h0600, 16'h0C00, 16'h0B00, 16'h0500, 16'h0A00
  };
  localparam logic [3:0] MIX_COEF_ENC [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
  localparam logic [3:0] MIX_COEF_DEC [4] = '{4'd14, 4'd11, 4'd13, 4'd9};

  typedef enum logic [1:0] {ROW_WRITE, ROW_BLOCK, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [IDX_W-1:0] index;
    logic             opv;
    logic [63:0]      value;
    logic [63:0]      known;
  } row_t;

  localparam int DIRECTED_ROWS = 29;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'h0000000000000000, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'h0000000000000000, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd1, 64'h0},
    '{ROW_KNOWN, REG_KEY,     OP_ENCRYPT, 64'h0000000000000000, 64'h0100010001000100},
    '{ROW_KNOWN, REG_KEY,     OP_DECRYPT, 64'h0100010001000100, 64'h0000000000000000},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd0, 64'h0},
    '{ROW_KNOWN, REG_KEY,     OP_ENCRYPT, 64'h0000000000000000, 64'h0100010001000100},
    '{ROW_KNOWN, REG_KEY,     OP_DECRYPT, 64'h0100010001000100, 64'h0000000000000000},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd15, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'h0123456789ABCDEF, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_WRITE, REG_SPARE_2, OP_ENCRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_WRITE, REG_SPARE_3, OP_ENCRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'h0000000000000000, 64'h0},
    '{ROW_WRITE, REG_KEY,     OP_ENCRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd10, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'h0000000000000000, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'h0000000000000000, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'hFFFFFFFFFFFFFFFF, 64'h0},
    '{ROW_WRITE, REG_KEY,     OP_ENCRYPT, 64'h0123456789ABCDEF, 64'h0},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd4, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'hFEDCBA9876543210, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'h0123456789ABCDEF, 64'h0},
    '{ROW_WRITE, REG_COUNT,   OP_ENCRYPT, 64'd2, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_ENCRYPT, 64'h5555555555555555, 64'h0},
    '{ROW_BLOCK, REG_KEY,     OP_DECRYPT, 64'hAAAAAAAAAAAAAAAA, 64'h0}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic                             op;
  logic [naes64_pkg::BLOCK_W-1:0]   data_block;
  logic                             out_valid;
  logic                             out_ready;
  logic [naes64_pkg::BLOCK_W-1:0]   result_block;
  logic                             cfg_write;
  logic [IDX_W-1:0]                 cfg_index;
  logic [naes64_pkg::BLOCK_W-1:0]   cfg_data;

  logic [63:0] shadow_key;
  logic [3:0]  shadow_rounds;
  logic [63:0] sched_keys [ROUNDS_MAX];
  logic [63:0] pending_results [$];
  logic [63:0] last_cipher;
  logic        have_cipher = 1'b0;
  logic        offering    = 1'b0;
  logic        tx_gaps_on  = 1'b1;
  logic        rx_idle_on  = 1'b1;
  logic        hold_off_req = 1'b0;
  int          mismatches  = 0;
  int          cycle_count = 0;

  nibble_aes64_cipher #(.MAX_ROUNDS(ROUNDS_MAX)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .data_block   (data_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] prod;
    logic [3:0] x;
    prod = 4'h0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        prod = prod ^ x;
      end
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return prod;
  endfunction

  function automatic logic [63:0] substitute(input logic [63:0] b, input bit inverse);
    for (int p = 0; p < 16; p++) begin
      b[63-4*p -: 4] = inverse ? SBOX_INV[b[63-4*p -: 4]] : SBOX[b[63-4*p -: 4]];
    end
    return b;
  endfunction

  // Nibble p moves to position 13*p mod 16 in the forward direction.
  function automatic logic [63:0] permute_rows(input logic [63:0] b, input bit inverse);
    logic [63:0] r;
    int dest;
    r = '0;
    for (int p = 0; p < 16; p++) begin
      dest = (13 * p) % 16;
      if (inverse) begin
        r[63-4*p -: 4] = b[63-4*dest -: 4];
      end else begin
        r[63-4*dest -: 4] = b[63-4*p -: 4];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] mix(input logic [63:0] b, input bit inverse);
    logic [63:0] r;
    logic [3:0]  acc;
    logic [3:0]  coef;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        acc = 4'h0;
        for (int k = 0; k < 4; k++) begin
          coef = inverse ? MIX_COEF_DEC[(k + 4 - row) % 4] : MIX_COEF_ENC[(k + 4 - row) % 4];
          acc = acc ^ gf16_mul(b[63-4*(4*c+k) -: 4], coef);
        end
        r[63-4*(4*c+row) -: 4] = acc;
      end
    end
    return r;
  endfunction

  function automatic void expand_round_keys();
    logic [63:0] cur;
    logic [15:0] t;
    logic [15:0] s;
    logic [15:0] w1, w2, w3, w4;
    cur = shadow_key;
    for (int i = 0; i < ROUNDS_MAX; i++) begin
      t = {cur[11:0], cur[15:12]};
      for (int n = 0; n < 4; n++) begin
        s[4*n +: 4] = SBOX[t[4*n +: 4]];
      end
      w1 = s ^ cur[63:48] ^ RCON[i];
      w2 = w1 ^ cur[47:32];
      w3 = w2 ^ cur[31:16];
      w4 = w3 ^ cur[15:0];
      cur = {w1, w2, w3, w4};
      sched_keys[i] = cur;
    end
  endfunction

  function automatic logic [63:0] predicted_block(input logic opv, input logic [63:0] blk);
    int          nr;
    logic [63:0] b;
    nr = shadow_rounds;
    if (nr < 1) begin
      nr = 1;
    end
    if (nr > ROUNDS_MAX) begin
      nr = ROUNDS_MAX;
    end
    b = blk;
    if (opv == OP_ENCRYPT) begin
      b = b ^ shadow_key;
      for (int r = 0; r < nr; r++) begin
        b = permute_rows(substitute(b, 1'b0), 1'b0);
        if (r + 1 < nr) begin
          b = mix(b, 1'b0);
        end
        b = b ^ sched_keys[r];
      end
    end else begin
      for (int r = 0; r < nr; r++) begin
        b = b ^ sched_keys[nr-1-r];
        if (r != 0) begin
          b = mix(b, 1'b1);
        end
        b = substitute(permute_rows(b, 1'b1), 1'b1);
      end
      b = b ^ shadow_key;
    end
    return b;
  endfunction

  function automatic logic [63:0] pick_block();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      stop_offering();
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (ROUNDS_MAX + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_KEY) begin
      shadow_key = val;
      expand_round_keys();
    end else if (idx == REG_COUNT) begin
      shadow_rounds = val[3:0];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_block(input logic opv, input logic [63:0] blk,
                            input bit use_known, input logic [63:0] known);
    logic [63:0] expected;
    op         <= opv;
    data_block <= blk;
    in_valid   <= 1'b1;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected = use_known ? known : predicted_block(opv, blk);
    pending_results.push_back(expected);
    if (opv == OP_ENCRYPT) begin
      last_cipher = expected;
      have_cipher = 1'b1;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result_block %h with no block pending", $time, result_block);
        mismatches++;
      end else if (result_block !== pending_results[0]) begin
        $display("%0t: result_block mismatch, expected %h, actual %h",
                 $time, pending_results[0], result_block);
        mismatches++;
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int          sent;
    int          phase;
    logic [63:0] word;
    logic        opv;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_DECRYPT;
    data_block = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_KEY;
    cfg_data   = '0;
    shadow_key    = '0;
    shadow_rounds = naes64_pkg::ROUND_COUNT_RESET;
    expand_round_keys();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        stop_offering();
        wait_idle();
        write_reg(DIRECTED[i].index, DIRECTED[i].value);
      end else begin
        maybe_gap();
        send_block(DIRECTED[i].opv, DIRECTED[i].value,
                   DIRECTED[i].kind == ROW_KNOWN, DIRECTED[i].known);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < ITEMS) begin
      stop_offering();
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_KEY, pick_block());
      end
      word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: word[3:0] = 4'd0;
        1: word[3:0] = 4'd1;
        2: word[3:0] = 4'(ROUNDS_MAX);
        3: word[3:0] = 4'd15;
        default: ;
      endcase
      write_reg(REG_COUNT, word);
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
      end
      if (sent >= ITEMS - 80) begin
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_gaps_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if (phase == 0) begin
        tx_gaps_on = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat ($urandom_range(20, 60)) begin
        maybe_gap();
        if (have_cipher && $urandom_range(0, 3) == 0) begin
          send_block(OP_DECRYPT, last_cipher, 1'b0, '0);
        end else begin
          opv = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
          send_block(opv, pick_block(), 1'b0, '0);
        end
        sent++;
      end
      phase++;
    end

    stop_offering();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ROUNDS_MAX + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/naes64_pkg.sv
src/naes64_ctrl.sv
src/naes64_datapath.sv
src/nibble_aes64_cipher.sv
sim/nibble_aes64_cipher_test.sv
